### hdl/sbsr_pkg.sv
// Shared types and constants for the servo bus status receiver.
// No dependencies; imported by every module of the block.
`default_nettype none
package sbsr_pkg;

  localparam int unsigned HUNT_LIMIT_DEF = 64;
  localparam logic [7:0]  HEADER_BYTE    = 8'hFF;
  localparam logic [8:0]  LEN_OVERHEAD   = 9'd2;

  // configuration register indexes
  localparam logic CFG_SERVO_ID  = 1'b0;
  localparam logic CFG_DATA_SIZE = 1'b1;

  typedef enum logic {
    ACT_BYTE    = 1'b0,
    ACT_TIMEOUT = 1'b1
  } action_e;

  typedef enum logic {
    KIND_DATA    = 1'b0,
    KIND_OUTCOME = 1'b1
  } kind_e;

  typedef enum logic [2:0] {
    OUT_OK      = 3'd0,
    OUT_NOHDR   = 3'd1,
    OUT_BADHDR  = 3'd2,
    OUT_CSUM    = 3'd3,
    OUT_TIMEOUT = 3'd4
  } outcome_e;

  typedef enum logic [2:0] {
    PH_HUNT   = 3'd0,
    PH_ID     = 3'd1,
    PH_LEN    = 3'd2,
    PH_STATUS = 3'd3,
    PH_DATA   = 3'd4,
    PH_CSUM   = 3'd5
  } phase_e;

  typedef struct packed {
    logic [7:0] servo_id;
    logic [7:0] data_size;
  } cfg_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
    logic [7:0] data_index;
    logic [2:0] outcome;
    logic       last;
  } result_t;

endpackage
`default_nettype wire

### hdl/sbsr_if.sv
// Valid/ready channel interfaces for the receiver's byte input and result output.
// Plain signals only; no package dependency.
`default_nettype none
interface sbsr_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] rx_byte;

  modport source (output valid, output action, output rx_byte, input ready);
  modport sink   (input valid, input action, input rx_byte, output ready);
endinterface

interface sbsr_out_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] data_byte;
  logic [7:0] data_index;
  logic [2:0] outcome;
  logic       last;

  modport source (output valid, output kind, output data_byte, output data_index,
                  output outcome, output last, input ready);
  modport sink   (input valid, input kind, input data_byte, input data_index,
                  input outcome, input last, output ready);
endinterface
`default_nettype wire

### hdl/sbsr_cfg_regs.sv
// Configuration registers of the receiver: expected ID and expected data size.
// Depends on sbsr_pkg.
`default_nettype none
module sbsr_cfg_regs (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          we_i,
  input  wire logic          idx_i,
  input  wire logic [7:0]    data_i,
  output sbsr_pkg::cfg_t     cfg_o
);
  import sbsr_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.servo_id  <= 8'd1;
      cfg_q.data_size <= 8'd0;
    end else if (we_i) begin
      case (idx_i)
        CFG_SERVO_ID:  cfg_q.servo_id  <= data_i;
        CFG_DATA_SIZE: cfg_q.data_size <= data_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

### hdl/sbsr_parser.sv
// Reply parser: header hunt, ID/length/status checks, data pass-out, checksum.
// Depends on sbsr_pkg. Updates its state on each step and gives at most one result.
`default_nettype none
module sbsr_parser #(
  parameter int unsigned HUNT_LIMIT = sbsr_pkg::HUNT_LIMIT_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          step_i,
  input  wire logic          action_i,
  input  wire logic [7:0]    rx_byte_i,
  input  wire sbsr_pkg::cfg_t cfg_i,
  output logic               res_valid_o,
  output sbsr_pkg::result_t  res_o
);
  import sbsr_pkg::*;

  localparam int unsigned HCW = $clog2(HUNT_LIMIT + 1);
  localparam logic [HCW-1:0] HUNT_LIMIT_C = HCW'(HUNT_LIMIT);

  phase_e         phase_q, phase_d;
  logic [HCW-1:0] hunt_cnt_q, hunt_cnt_d;
  logic           prev_hdr_q, prev_hdr_d;
  logic [7:0]     sum_q, sum_d;
  logic [7:0]     data_cnt_q, data_cnt_d;
  logic           hdr_bad_q, hdr_bad_d;

  logic [HCW-1:0] hunt_inc;
  logic [7:0]     sum_add;
  logic [7:0]     data_inc;
  logic           is_hdr;
  logic           data_done;
  logic           csum_ok;
  logic           len_bad;
  logic           status_bad;

  assign is_hdr     = (rx_byte_i == HEADER_BYTE);
  assign hunt_inc   = hunt_cnt_q + HCW'(1);
  assign sum_add    = sum_q + rx_byte_i;
  assign data_inc   = data_cnt_q + 8'd1;
  assign data_done  = (data_cnt_q >= cfg_i.data_size);
  assign csum_ok    = (~sum_q == rx_byte_i);
  assign len_bad    = ({1'b0, rx_byte_i} != ({1'b0, cfg_i.data_size} + LEN_OVERHEAD));
  assign status_bad = hdr_bad_q || (rx_byte_i != 8'd0);

  // next state
  always_comb begin
    phase_d    = phase_q;
    hunt_cnt_d = hunt_cnt_q;
    prev_hdr_d = prev_hdr_q;
    sum_d      = sum_q;
    data_cnt_d = data_cnt_q;
    hdr_bad_d  = hdr_bad_q;
    if (action_i == ACT_TIMEOUT) begin
      phase_d = PH_HUNT;
    end else begin
      case (phase_q)
        PH_HUNT: begin
          if (prev_hdr_q && is_hdr) begin
            phase_d = PH_ID;
          end else begin
            prev_hdr_d = is_hdr;
            hunt_cnt_d = hunt_inc;
            if (hunt_inc >= HUNT_LIMIT_C) phase_d = PH_HUNT;
          end
        end
        PH_ID: begin
          sum_d     = rx_byte_i;
          hdr_bad_d = (rx_byte_i != cfg_i.servo_id);
          phase_d   = PH_LEN;
        end
        PH_LEN: begin
          sum_d   = sum_add;
          if (len_bad) hdr_bad_d = 1'b1;
          phase_d = PH_STATUS;
        end
        PH_STATUS: begin
          sum_d      = sum_add;
          data_cnt_d = 8'd0;
          if (status_bad)                    phase_d = PH_HUNT;
          else if (cfg_i.data_size == 8'd0)  phase_d = PH_CSUM;
          else                               phase_d = PH_DATA;
        end
        PH_DATA: begin
          if (data_done) begin
            phase_d = PH_HUNT;
          end else begin
            sum_d      = sum_add;
            data_cnt_d = data_inc;
            if (data_inc >= cfg_i.data_size) phase_d = PH_CSUM;
          end
        end
        PH_CSUM: phase_d = PH_HUNT;
        default: phase_d = PH_HUNT;
      endcase
    end
    // every return to the hunt starts from a clean slate
    if (phase_d == PH_HUNT && !(phase_q == PH_HUNT && hunt_inc < HUNT_LIMIT_C
                                && action_i == ACT_BYTE)) begin
      hunt_cnt_d = '0;
      prev_hdr_d = 1'b0;
      sum_d      = 8'd0;
      data_cnt_d = 8'd0;
      hdr_bad_d  = 1'b0;
    end
  end

  // result
  always_comb begin
    res_valid_o      = 1'b0;
    res_o.kind       = KIND_OUTCOME;
    res_o.data_byte  = 8'd0;
    res_o.data_index = 8'd0;
    res_o.outcome    = OUT_OK;
    res_o.last       = 1'b1;
    if (action_i == ACT_TIMEOUT) begin
      res_valid_o   = 1'b1;
      res_o.outcome = OUT_TIMEOUT;
    end else begin
      case (phase_q)
        PH_HUNT: begin
          if (!(prev_hdr_q && is_hdr) && hunt_inc >= HUNT_LIMIT_C) begin
            res_valid_o   = 1'b1;
            res_o.outcome = OUT_NOHDR;
          end
        end
        PH_STATUS: begin
          if (status_bad) begin
            res_valid_o   = 1'b1;
            res_o.outcome = OUT_BADHDR;
          end
        end
        PH_DATA: begin
          res_valid_o = 1'b1;
          if (data_done) begin
            res_o.outcome = csum_ok ? OUT_OK : OUT_CSUM;
          end else begin
            res_o.kind       = KIND_DATA;
            res_o.data_byte  = rx_byte_i;
            res_o.data_index = data_cnt_q;
            res_o.last       = 1'b0;
          end
        end
        PH_CSUM: begin
          res_valid_o   = 1'b1;
          res_o.outcome = csum_ok ? OUT_OK : OUT_CSUM;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_HUNT;
      hunt_cnt_q <= '0;
      prev_hdr_q <= 1'b0;
      sum_q      <= 8'd0;
      data_cnt_q <= 8'd0;
      hdr_bad_q  <= 1'b0;
    end else if (step_i) begin
      phase_q    <= phase_d;
      hunt_cnt_q <= hunt_cnt_d;
      prev_hdr_q <= prev_hdr_d;
      sum_q      <= sum_d;
      data_cnt_q <= data_cnt_d;
      hdr_bad_q  <= hdr_bad_d;
    end
  end

endmodule
`default_nettype wire

### hdl/servo_bus_status_receiver_top.sv
// Servo bus status receiver: input register, reply parser, output register.
// Depends on sbsr_pkg, sbsr_if, sbsr_cfg_regs and sbsr_parser.
//
// Takes one request (a received byte or a read timeout) per cycle and gives at
// most one result per request. The request is held in the input register and is
// parsed on its way into the output register, whose valid bit drives out_ch.valid.
// A new request is accepted every cycle while results are taken; the output register
// holds a result that waits, and the input register keeps the next request until it
// can move on. The user writes configuration through the plain write port only while
// no request is in flight; the block itself does not enforce this. A write between
// bytes of a reply takes effect from the next byte.
`default_nettype none
module servo_bus_status_receiver_top #(
  parameter int unsigned HUNT_LIMIT = sbsr_pkg::HUNT_LIMIT_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  sbsr_in_if.sink    in_ch,
  sbsr_out_if.source out_ch,
  input  wire logic  cfg_we_i,
  input  wire logic  cfg_idx_i,
  input  wire logic [7:0] cfg_data_i
);
  import sbsr_pkg::*;

  cfg_t       cfg;
  logic       in_vld_q;
  logic       in_action_q;
  logic [7:0] in_byte_q;
  logic       out_vld_q;
  result_t    out_q;
  logic       out_free;
  logic       step;
  logic       in_ready;
  logic       res_valid;
  result_t    res;

  assign out_free = !out_vld_q || out_ch.ready;
  assign step     = in_vld_q && out_free;
  assign in_ready = !in_vld_q || out_free;

  sbsr_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (cfg_we_i),
    .idx_i  (cfg_idx_i),
    .data_i (cfg_data_i),
    .cfg_o  (cfg)
  );

  sbsr_parser #(
    .HUNT_LIMIT (HUNT_LIMIT)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .action_i    (in_action_q),
    .rx_byte_i   (in_byte_q),
    .cfg_i       (cfg),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_ready)  in_vld_q  <= in_ch.valid;
      if (out_free)  out_vld_q <= step && res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && in_ch.valid) begin
      in_action_q <= in_ch.action;
      in_byte_q   <= in_ch.rx_byte;
    end
    if (step && res_valid) out_q <= res;
  end

  assign in_ch.ready       = in_ready;
  assign out_ch.valid      = out_vld_q;
  assign out_ch.kind       = out_q.kind;
  assign out_ch.data_byte  = out_q.data_byte;
  assign out_ch.data_index = out_q.data_index;
  assign out_ch.outcome    = out_q.outcome;
  assign out_ch.last       = out_q.last;

  // a request stalled in the input register must not change
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && !out_free |=> in_vld_q && $stable(in_byte_q) && $stable(in_action_q))
    else $error("stalled input request changed");

  // back-pressure only comes from a full input register
  a_ready_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready |-> in_vld_q && out_vld_q)
    else $error("input not ready without a stalled request");

  // a timeout always yields an outcome result
  a_timeout: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && in_action_q == ACT_TIMEOUT |=> out_vld_q && out_q.outcome == OUT_TIMEOUT
      && out_q.last)
    else $error("timeout did not end the reply");

  // data results never carry an outcome and never close a reply
  a_data_fmt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_q.kind == KIND_DATA |-> !out_q.last && out_q.outcome == OUT_OK)
    else $error("malformed data result");

endmodule
`default_nettype wire
